@@ src/mava_pkg.sv @@
// Types, constants and the operation schedule for the mesh area and volume accumulator.
package mava_pkg;

  localparam int CoordBits = 24;
  localparam int EdgeBits  = CoordBits + 1;
  localparam int CrossBits = 2 * CoordBits + 2;
  localparam int AccBits   = 4 * CoordBits + 5;
  localparam int MulBBits  = 2 * CoordBits + 2;
  localparam int RootBits  = 2 * CoordBits + 2;
  localparam int PerimBits = CoordBits + 4;
  localparam int PrecBits  = 24;
  localparam int AreaBits  = 63;
  localparam int VolBits   = 64;
  localparam int NumUops   = 22;
  localparam int UopBits   = 5;
  localparam int NumSrc    = 17;

  typedef struct packed {
    logic signed [CoordBits-1:0] first_x;
    logic signed [CoordBits-1:0] first_y;
    logic signed [CoordBits-1:0] first_z;
    logic signed [CoordBits-1:0] second_x;
    logic signed [CoordBits-1:0] second_y;
    logic signed [CoordBits-1:0] second_z;
    logic signed [CoordBits-1:0] third_x;
    logic signed [CoordBits-1:0] third_y;
    logic signed [CoordBits-1:0] third_z;
    logic                        last_triangle;
  } in_item_t;

  typedef struct packed {
    logic [AreaBits-1:0]       surface_area;
    logic signed [VolBits-1:0] enclosed_volume;
    logic                      overflowed;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ISSUE, ST_MAC, ST_SQRT, ST_DIV, ST_UPDATE, ST_EMIT
  } state_e;

  typedef enum logic [4:0] {
    SRC_E0X, SRC_E0Y, SRC_E0Z, SRC_E1X, SRC_E1Y, SRC_E1Z, SRC_E2X, SRC_E2Y, SRC_E2Z,
    SRC_C0, SRC_C1, SRC_C2, SRC_PERIM, SRC_PREC, SRC_V0X, SRC_V0Y, SRC_V0Z
  } src_e;

  typedef enum logic [2:0] {
    POST_NONE, POST_PERIM, POST_C0, POST_C1, POST_C2, POST_DBL, POST_THR, POST_VOL
  } post_e;

  typedef struct packed {
    src_e  a;
    src_e  b;
    logic  neg;
    logic  clr;
    post_e post;
  } uop_t;

  function automatic uop_t uop_at(logic [UopBits-1:0] idx);
    uop_t u;
    u = '{a: SRC_E0X, b: SRC_E0X, neg: 1'b0, clr: 1'b1, post: POST_NONE};
    unique case (idx)
      5'd0:  u = '{a: SRC_E0X, b: SRC_E0X, neg: 1'b0, clr: 1'b1, post: POST_NONE};
      5'd1:  u = '{a: SRC_E0Y, b: SRC_E0Y, neg: 1'b0, clr: 1'b0, post: POST_NONE};
      5'd2:  u = '{a: SRC_E0Z, b: SRC_E0Z, neg: 1'b0, clr: 1'b0, post: POST_PERIM};
      5'd3:  u = '{a: SRC_E1X, b: SRC_E1X, neg: 1'b0, clr: 1'b1, post: POST_NONE};
      5'd4:  u = '{a: SRC_E1Y, b: SRC_E1Y, neg: 1'b0, clr: 1'b0, post: POST_NONE};
      5'd5:  u = '{a: SRC_E1Z, b: SRC_E1Z, neg: 1'b0, clr: 1'b0, post: POST_PERIM};
      5'd6:  u = '{a: SRC_E2X, b: SRC_E2X, neg: 1'b0, clr: 1'b1, post: POST_NONE};
      5'd7:  u = '{a: SRC_E2Y, b: SRC_E2Y, neg: 1'b0, clr: 1'b0, post: POST_NONE};
      5'd8:  u = '{a: SRC_E2Z, b: SRC_E2Z, neg: 1'b0, clr: 1'b0, post: POST_PERIM};
      5'd9:  u = '{a: SRC_E0Y, b: SRC_E1Z, neg: 1'b0, clr: 1'b1, post: POST_NONE};
      5'd10: u = '{a: SRC_E0Z, b: SRC_E1Y, neg: 1'b1, clr: 1'b0, post: POST_C0};
      5'd11: u = '{a: SRC_E0Z, b: SRC_E1X, neg: 1'b0, clr: 1'b1, post: POST_NONE};
      5'd12: u = '{a: SRC_E0X, b: SRC_E1Z, neg: 1'b1, clr: 1'b0, post: POST_C1};
      5'd13: u = '{a: SRC_E0X, b: SRC_E1Y, neg: 1'b0, clr: 1'b1, post: POST_NONE};
      5'd14: u = '{a: SRC_E0Y, b: SRC_E1X, neg: 1'b1, clr: 1'b0, post: POST_C2};
      5'd15: u = '{a: SRC_C0, b: SRC_C0, neg: 1'b0, clr: 1'b1, post: POST_NONE};
      5'd16: u = '{a: SRC_C1, b: SRC_C1, neg: 1'b0, clr: 1'b0, post: POST_NONE};
      5'd17: u = '{a: SRC_C2, b: SRC_C2, neg: 1'b0, clr: 1'b0, post: POST_DBL};
      5'd18: u = '{a: SRC_PERIM, b: SRC_PREC, neg: 1'b0, clr: 1'b1, post: POST_THR};
      5'd19: u = '{a: SRC_C0, b: SRC_V0X, neg: 1'b0, clr: 1'b1, post: POST_NONE};
      5'd20: u = '{a: SRC_C1, b: SRC_V0Y, neg: 1'b0, clr: 1'b0, post: POST_NONE};
      5'd21: u = '{a: SRC_C2, b: SRC_V0Z, neg: 1'b0, clr: 1'b0, post: POST_VOL};
      default: u = '{a: SRC_E0X, b: SRC_E0X, neg: 1'b0, clr: 1'b1, post: POST_NONE};
    endcase
    return u;
  endfunction

endpackage

@@ src/mava_mac.sv @@
// Shift-and-add multiply-accumulate unit, one partial product per cycle.
module mava_mac (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  logic                                   clr_i,
  input  logic signed [mava_pkg::AccBits-1:0]    a_i,
  input  logic signed [mava_pkg::MulBBits-1:0]   b_i,
  output logic                                   done_o,
  output logic signed [mava_pkg::AccBits-1:0]    acc_o
);

  logic                                 run_q;
  logic signed [mava_pkg::AccBits-1:0]  acc_q, ma_q;
  logic [mava_pkg::MulBBits-1:0]        mb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
    end else if (start_i) begin
      run_q <= 1'b1;
    end else if (run_q && mb_q == '0) begin
      run_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      if (clr_i) begin
        acc_q <= '0;
      end
      ma_q <= b_i[mava_pkg::MulBBits-1] ? -a_i : a_i;
      mb_q <= b_i[mava_pkg::MulBBits-1] ? -b_i : b_i;
    end else if (run_q && mb_q != '0) begin
      if (mb_q[0]) begin
        acc_q <= acc_q + ma_q;
      end
      ma_q <= ma_q <<< 1;
      mb_q <= mb_q >> 1;
    end
  end

  assign done_o = run_q && mb_q == '0;
  assign acc_o  = acc_q;

endmodule

@@ src/mava_sqrt.sv @@
// Digit-by-digit integer square root, one result bit per cycle.
module mava_sqrt (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [2*mava_pkg::RootBits-1:0]     rad_i,
  output logic                                done_o,
  output logic [mava_pkg::RootBits-1:0]       root_o
);

  localparam int Rb = mava_pkg::RootBits;
  localparam int Cb = $clog2(Rb + 1);

  logic             run_q;
  logic [Cb-1:0]    cnt_q;
  logic [2*Rb-1:0]  rad_q;
  logic [Rb:0]      rem_q;
  logic [Rb-1:0]    root_q;
  logic [Rb+2:0]    part;
  logic [Rb+2:0]    trial;
  logic             fits;

  assign part  = {rem_q, rad_q[2*Rb-1 -: 2]};
  assign trial = {1'b0, root_q, 2'b01};
  assign fits  = part >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else if (start_i) begin
      run_q <= 1'b1;
      cnt_q <= Cb'(Rb);
    end else if (run_q) begin
      if (cnt_q == '0) begin
        run_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (run_q && cnt_q != '0) begin
      rad_q  <= rad_q << 2;
      rem_q  <= fits ? (Rb+1)'(part - trial) : part[Rb:0];
      root_q <= {root_q[Rb-2:0], fits};
    end
  end

  assign done_o = run_q && cnt_q == '0;
  assign root_o = root_q;

endmodule

@@ src/mava_div6.sv @@
// Division by six, sixteen dividend bits per cycle through a reciprocal multiply.
module mava_div6 (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [mava_pkg::AccBits-1:0]      num_i,
  output logic                              done_o,
  output logic [mava_pkg::AccBits-1:0]      quo_o
);

  localparam int Ab = mava_pkg::AccBits;
  localparam int Db = 16;
  localparam int Nd = (Ab + Db - 1) / Db;
  localparam int Pb = Nd * Db;
  localparam int Cb = $clog2(Nd + 1);
  localparam int Tb = Db + 3;
  localparam int Sh = Tb + 3;
  localparam int Mb = Tb + Sh;
  localparam logic [Sh-1:0] Recip = Sh'((64'd1 << Sh) / 6 + 1);

  logic          run_q;
  logic [Cb-1:0] cnt_q;
  logic [Pb-1:0] num_q;
  logic [Ab-1:0] quo_q;
  logic [2:0]    rem_q;
  logic [Tb-1:0] part;
  logic [Mb-1:0] prod;
  logic [Db-1:0] qd;
  logic [Tb-1:0] back;

  assign part = {rem_q, num_q[Pb-1 -: Db]};
  assign prod = Mb'(part) * Mb'(Recip);
  assign qd   = prod[Sh +: Db];
  assign back = part - Tb'({qd, 2'b00}) - Tb'({qd, 1'b0});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else if (start_i) begin
      run_q <= 1'b1;
      cnt_q <= Cb'(Nd);
    end else if (run_q) begin
      if (cnt_q == '0) begin
        run_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= {{(Pb-Ab){1'b0}}, num_i};
      quo_q <= '0;
      rem_q <= '0;
    end else if (run_q && cnt_q != '0) begin
      num_q <= num_q << Db;
      quo_q <= {quo_q[Ab-Db-1:0], qd};
      rem_q <= back[2:0];
    end
  end

  assign done_o = run_q && cnt_q == '0;
  assign quo_o  = quo_q;

endmodule

@@ src/mesh_area_volume_accumulator_unit.sv @@
// Top level of the triangle mesh surface area and signed volume accumulator.
// Each input item is one triangle given by three vertices in signed Q15.8.
// An item is taken when in_valid_i is high and in_stall_o is low; in_stall_o
// stays high from acceptance until the triangle is fully processed.
// The triangle is worked through a fixed schedule of 22 multiply-accumulate
// steps on one shift-and-add multiplier, four square roots on one digit-serial
// root unit and one division by six that retires sixteen bits per cycle.
// A multiply step lasts longer the more bits the magnitude of its second
// operand has, so the time from acceptance until the next item can be
// taken depends on the coordinates of the triangle.
// After a triangle with last_triangle set, the totals are placed in the output
// register and cleared; out_valid_o then holds until out_stall_i is low.
// If the previous result is still waiting, the block holds until it is taken.
// Reset clears the totals, the overflow flag, the tolerance register and the
// output valid flag. cfg_we_i writes the degeneracy tolerance; write it only
// while the block is idle.
module mesh_area_volume_accumulator_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  mava_pkg::in_item_t          in_item_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output mava_pkg::out_item_t         out_item_o,
  input  logic                        cfg_we_i,
  input  logic [mava_pkg::PrecBits-1:0] cfg_wdata_i
);

  localparam int Cw = mava_pkg::CoordBits;
  localparam int Ew = mava_pkg::EdgeBits;
  localparam int Aw = mava_pkg::AccBits;
  localparam int Rw = mava_pkg::RootBits;
  localparam int Pw = mava_pkg::PerimBits;
  localparam int Xw = mava_pkg::CrossBits;
  localparam logic [63:0] AreaMax = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] VolMin  = 64'h8000_0000_0000_0000;

  mava_pkg::state_e state_q, state_d;
  logic [mava_pkg::UopBits-1:0] step_q;
  mava_pkg::uop_t uop;

  logic [mava_pkg::PrecBits-1:0] prec_q;
  logic signed [Cw-1:0] v_q [3][3];
  logic                 last_q;
  logic signed [Ew-1:0] e [3][3];
  logic signed [Xw-1:0] c_q [3];
  logic [Pw-1:0]        perim_q;
  logic [Rw-1:0]        dbl_q;
  logic [Aw-1:0]        thr_q;
  logic                 vneg_q;

  logic [mava_pkg::AreaBits-1:0] area_q;
  logic signed [63:0]            vol_q;
  logic                          ovf_q;
  logic                          out_valid_q;
  mava_pkg::out_item_t           out_q;

  logic signed [Aw-1:0] src_val [mava_pkg::NumSrc];
  logic signed [Aw-1:0] a_op;
  logic                 mac_start, mac_done, sqrt_start, sqrt_done, div_start, div_done;
  logic signed [Aw-1:0] acc;
  logic [Rw-1:0]        root;
  logic [Aw-1:0]        quo;
  logic [Aw-1:0]        acc_mag;

  logic                 take;
  logic [63:0]          half_ext;
  logic [63:0]          area_sum;
  logic [62:0]          area_d;
  logic                 area_ovf;
  logic [63:0]          vc;
  logic                 vc_ovf;
  logic [64:0]          vsum;
  logic [63:0]          vol_d;
  logic                 vol_ovf;
  logic                 out_free;

  assign uop = mava_pkg::uop_at(step_q);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        e[i][k] = Ew'(v_q[(i + 1) % 3][k]) - Ew'(v_q[i][k]);
      end
    end
  end

  always_comb begin
    src_val[mava_pkg::SRC_E0X]   = Aw'(e[0][0]);
    src_val[mava_pkg::SRC_E0Y]   = Aw'(e[0][1]);
    src_val[mava_pkg::SRC_E0Z]   = Aw'(e[0][2]);
    src_val[mava_pkg::SRC_E1X]   = Aw'(e[1][0]);
    src_val[mava_pkg::SRC_E1Y]   = Aw'(e[1][1]);
    src_val[mava_pkg::SRC_E1Z]   = Aw'(e[1][2]);
    src_val[mava_pkg::SRC_E2X]   = Aw'(e[2][0]);
    src_val[mava_pkg::SRC_E2Y]   = Aw'(e[2][1]);
    src_val[mava_pkg::SRC_E2Z]   = Aw'(e[2][2]);
    src_val[mava_pkg::SRC_C0]    = Aw'(c_q[0]);
    src_val[mava_pkg::SRC_C1]    = Aw'(c_q[1]);
    src_val[mava_pkg::SRC_C2]    = Aw'(c_q[2]);
    src_val[mava_pkg::SRC_PERIM] = Aw'({1'b0, perim_q});
    src_val[mava_pkg::SRC_PREC]  = Aw'({1'b0, prec_q});
    src_val[mava_pkg::SRC_V0X]   = Aw'(v_q[0][0]);
    src_val[mava_pkg::SRC_V0Y]   = Aw'(v_q[0][1]);
    src_val[mava_pkg::SRC_V0Z]   = Aw'(v_q[0][2]);
  end

  assign a_op = uop.neg ? -src_val[uop.a] : src_val[uop.a];
  assign acc_mag = acc[Aw-1] ? -acc : acc;

  mava_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mac_start),
    .clr_i  (uop.clr),
    .a_i    (a_op),
    .b_i    (mava_pkg::MulBBits'(src_val[uop.b])),
    .done_o (mac_done),
    .acc_o  (acc)
  );

  mava_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(sqrt_start),
    .rad_i  (acc[2*Rw-1:0]),
    .done_o (sqrt_done),
    .root_o (root)
  );

  mava_div6 u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (acc_mag),
    .done_o (div_done),
    .quo_o  (quo)
  );

  always_comb begin
    take     = {{(Aw-Rw){1'b0}}, dbl_q} > thr_q;
    half_ext = 64'(dbl_q >> 1);
    area_sum = {1'b0, area_q} + {1'b0, half_ext[62:0]};
    area_ovf = half_ext[63] || area_sum[63];
    area_d   = area_ovf ? AreaMax[62:0] : area_sum[62:0];
    vc_ovf   = 1'b0;
    if (vneg_q) begin
      if (quo[Aw-1:64] == '0 && quo[63:0] <= VolMin) begin
        vc = -quo[63:0];
      end else begin
        vc     = VolMin;
        vc_ovf = 1'b1;
      end
    end else begin
      if (quo[Aw-1:63] == '0) begin
        vc = quo[63:0];
      end else begin
        vc     = AreaMax;
        vc_ovf = 1'b1;
      end
    end
    vsum    = {vol_q[63], vol_q} + {vc[63], vc};
    vol_ovf = vsum[64] != vsum[63];
    vol_d   = vol_ovf ? (vsum[64] ? VolMin : AreaMax) : vsum[63:0];
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d    = state_q;
    mac_start  = 1'b0;
    sqrt_start = 1'b0;
    div_start  = 1'b0;
    unique case (state_q)
      mava_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = mava_pkg::ST_ISSUE;
        end
      end
      mava_pkg::ST_ISSUE: begin
        mac_start = 1'b1;
        state_d   = mava_pkg::ST_MAC;
      end
      mava_pkg::ST_MAC: begin
        if (mac_done) begin
          unique case (uop.post) inside
            mava_pkg::POST_PERIM, mava_pkg::POST_DBL: begin
              sqrt_start = 1'b1;
              state_d    = mava_pkg::ST_SQRT;
            end
            mava_pkg::POST_VOL: begin
              div_start = 1'b1;
              state_d   = mava_pkg::ST_DIV;
            end
            default: state_d = mava_pkg::ST_ISSUE;
          endcase
        end
      end
      mava_pkg::ST_SQRT: begin
        if (sqrt_done) begin
          state_d = mava_pkg::ST_ISSUE;
        end
      end
      mava_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = mava_pkg::ST_UPDATE;
        end
      end
      mava_pkg::ST_UPDATE: begin
        state_d = last_q ? mava_pkg::ST_EMIT : mava_pkg::ST_IDLE;
      end
      mava_pkg::ST_EMIT: begin
        if (out_free) begin
          state_d = mava_pkg::ST_IDLE;
        end
      end
      default: state_d = mava_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mava_pkg::ST_IDLE;
      step_q      <= '0;
      prec_q      <= '0;
      area_q      <= '0;
      vol_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        prec_q <= cfg_wdata_i;
      end
      if (state_q == mava_pkg::ST_IDLE) begin
        step_q <= '0;
      end else if ((state_q == mava_pkg::ST_MAC && mac_done &&
                    uop.post != mava_pkg::POST_PERIM && uop.post != mava_pkg::POST_DBL &&
                    uop.post != mava_pkg::POST_VOL) ||
                   (state_q == mava_pkg::ST_SQRT && sqrt_done)) begin
        step_q <= step_q + 1'b1;
      end
      if (state_q == mava_pkg::ST_UPDATE && take) begin
        area_q <= area_d;
        vol_q  <= vol_d;
        ovf_q  <= ovf_q | area_ovf | vc_ovf | vol_ovf;
      end
      if (state_q == mava_pkg::ST_EMIT && out_free) begin
        out_valid_q <= 1'b1;
        area_q      <= '0;
        vol_q       <= '0;
        ovf_q       <= 1'b0;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == mava_pkg::ST_IDLE && in_valid_i) begin
      v_q[0][0] <= in_item_i.first_x;
      v_q[0][1] <= in_item_i.first_y;
      v_q[0][2] <= in_item_i.first_z;
      v_q[1][0] <= in_item_i.second_x;
      v_q[1][1] <= in_item_i.second_y;
      v_q[1][2] <= in_item_i.second_z;
      v_q[2][0] <= in_item_i.third_x;
      v_q[2][1] <= in_item_i.third_y;
      v_q[2][2] <= in_item_i.third_z;
      last_q    <= in_item_i.last_triangle;
      perim_q   <= '0;
    end
    if (state_q == mava_pkg::ST_MAC && mac_done) begin
      case (uop.post)
        mava_pkg::POST_C0:  c_q[0] <= Xw'(acc);
        mava_pkg::POST_C1:  c_q[1] <= Xw'(acc);
        mava_pkg::POST_C2:  c_q[2] <= Xw'(acc);
        mava_pkg::POST_THR: thr_q  <= acc;
        mava_pkg::POST_VOL: vneg_q <= acc[Aw-1];
        default: ;
      endcase
    end
    if (state_q == mava_pkg::ST_SQRT && sqrt_done) begin
      if (uop.post == mava_pkg::POST_PERIM) begin
        perim_q <= perim_q + Pw'(root);
      end else begin
        dbl_q <= root;
      end
    end
    if (state_q == mava_pkg::ST_EMIT && out_free) begin
      out_q.surface_area    <= area_q;
      out_q.enclosed_volume <= vol_q;
      out_q.overflowed      <= ovf_q;
    end
  end

  assign in_stall_o  = state_q != mava_pkg::ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
